/* src/mhlr_pkg.sv */
// ----------------------------------------------------------------------------
// mhlr_pkg
// Shared types and constants of the min-heap operation log repair block.
// ----------------------------------------------------------------------------
package mhlr_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CHECK,
    ST_INS_EMIT,
    ST_PUSH_START,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_PUSH_END,
    ST_POP_START,
    ST_POP_LAST,
    ST_POP_RL,
    ST_POP_RR,
    ST_POP_CMP,
    ST_POP_END,
    ST_GET_RD,
    ST_GET_CMP,
    ST_GET_EMIT,
    ST_REM_EMIT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SET_ERR,
    DP_PUSH_START,
    DP_PUSH_MOVE,
    DP_PUSH_END,
    DP_POP_START,
    DP_POP_LAST,
    DP_LOAD_LVAL,
    DP_SINK_RD_L,
    DP_SINK_LV_L,
    DP_SINK_RD_R,
    DP_POP_END
  } dp_op_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT,
    RD_PARENT
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
    logic    emit;
    op_t     emit_op;
    logic    emit_one;
    logic    emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd_ins;
    logic cmd_rem;
    logic cnt_zero;
    logic cnt_full;
    logic idx_zero;
    logic l_in;
    logic r_in;
    logic rd_lt_val;
    logic rd_eq_val;
    logic rd_lt_mov;
    logic rd_lt_lval;
    logic lval_lt_mov;
  } dp_stat_t;

endpackage

/* src/mhlr_ram.sv */
// ----------------------------------------------------------------------------
// mhlr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhlr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mhlr_dp.sv */
// ----------------------------------------------------------------------------
// mhlr_dp
// Datapath: heap store, element count, hole index, moving element and the
// registered result ports.
// ----------------------------------------------------------------------------
module mhlr_dp #(
  parameter int CAPACITY = mhlr_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mhlr_pkg::ctrl_cmd_t                cmd,
  output mhlr_pkg::dp_stat_t                 stat,
  input  logic [mhlr_pkg::OP_W-1:0]          command,
  input  logic signed [mhlr_pkg::VAL_W-1:0]  value,
  output logic                               valid,
  output logic [mhlr_pkg::OP_W-1:0]          op,
  output logic signed [mhlr_pkg::VAL_W-1:0]  op_value,
  output logic                               last,
  output logic                               full_error
);
  import mhlr_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;

  logic [OP_W-1:0]         cmd_r;
  logic signed [VAL_W-1:0] val;
  logic signed [VAL_W-1:0] mov;
  logic signed [VAL_W-1:0] lval;
  logic [CW-1:0]           cnt;
  logic [IW-1:0]           idx;
  logic                    err_r;
  logic                    valid_r;
  op_t                     op_r;
  logic signed [VAL_W-1:0] op_value_r;
  logic                    last_r;
  logic                    full_r;

  logic [XW-1:0]           l_x;
  logic [XW-1:0]           r_x;
  logic [XW-1:0]           cnt_x;
  logic [IW-1:0]           parent;
  logic [IW-1:0]           last_a;
  logic [IW-1:0]           raddr;
  logic signed [VAL_W-1:0] rdata;
  logic                    we;
  logic signed [VAL_W-1:0] wdata;
  logic signed [VAL_W-1:0] emit_val;

  assign l_x    = XW'({idx, 1'b1});
  assign r_x    = l_x + XW'(1);
  assign cnt_x  = XW'(cnt);
  assign parent = IW'((idx - IW'(1)) >> 1);
  assign last_a = IW'(cnt - CW'(1));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_LAST:   raddr = last_a;
      RD_LEFT:   raddr = l_x[IW-1:0];
      RD_RIGHT:  raddr = r_x[IW-1:0];
      RD_PARENT: raddr = parent;
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    unique case (cmd.op)
      DP_PUSH_MOVE, DP_SINK_RD_L, DP_SINK_RD_R: we = 1'b1;
      DP_SINK_LV_L: begin
        we    = 1'b1;
        wdata = lval;
      end
      DP_PUSH_END: begin
        we    = 1'b1;
        wdata = val;
      end
      DP_POP_END: begin
        we    = 1'b1;
        wdata = mov;
      end
      default: ;
    endcase
  end

  mhlr_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(idx),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    stat.cmd_ins     = (cmd_r == OP_INSERT);
    stat.cmd_rem     = (cmd_r == OP_REMOVE);
    stat.cnt_zero    = (cnt == '0);
    stat.cnt_full    = (cnt == CW'(CAPACITY));
    stat.idx_zero    = (idx == '0);
    stat.l_in        = (l_x < cnt_x);
    stat.r_in        = (r_x < cnt_x);
    stat.rd_lt_val   = (rdata < val);
    stat.rd_eq_val   = (rdata == val);
    stat.rd_lt_mov   = (rdata < mov);
    stat.rd_lt_lval  = (rdata < lval);
    stat.lval_lt_mov = (lval < mov);
  end

  always_comb begin
    unique case (cmd.emit_op)
      OP_INSERT: emit_val = cmd.emit_one ? VAL_W'(1) : val;
      OP_GET:    emit_val = val;
      default:   emit_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      err_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      unique case (cmd.op)
        DP_LOAD:       err_r <= 1'b0;
        DP_SET_ERR:    err_r <= stat.cnt_full;
        DP_PUSH_START: cnt   <= cnt + CW'(1);
        DP_POP_START:  cnt   <= cnt - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        cmd_r <= command;
        val   <= value;
      end
      DP_PUSH_START: idx  <= cnt[IW-1:0];
      DP_PUSH_MOVE:  idx  <= parent;
      DP_POP_START:  idx  <= '0;
      DP_POP_LAST:   mov  <= rdata;
      DP_LOAD_LVAL:  lval <= rdata;
      DP_SINK_RD_L:  idx  <= l_x[IW-1:0];
      DP_SINK_LV_L:  idx  <= l_x[IW-1:0];
      DP_SINK_RD_R:  idx  <= r_x[IW-1:0];
      default: ;
    endcase
    if (cmd.emit) begin
      op_r       <= cmd.emit_op;
      op_value_r <= emit_val;
      last_r     <= cmd.emit_last;
      full_r     <= err_r;
    end
  end

  assign valid      = valid_r;
  assign op         = op_r;
  assign op_value   = op_value_r;
  assign last       = last_r;
  assign full_error = full_r;

endmodule

/* src/mhlr_ctrl.sv */
// ----------------------------------------------------------------------------
// mhlr_ctrl
// Controller: sequences insert, removeMin and getMin repair, heap sift-up
// and sift-down, and result emission.
// ----------------------------------------------------------------------------
module mhlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mhlr_pkg::dp_stat_t  stat,
  output mhlr_pkg::ctrl_cmd_t cmd
);
  import mhlr_pkg::*;

  state_t state;
  state_t state_next;
  logic   pick_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign pick_right = stat.lval_lt_mov ? stat.rd_lt_lval : stat.rd_lt_mov;
  assign busy       = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd.op        = DP_NOP;
    cmd.rd_sel    = RD_ROOT;
    cmd.emit      = 1'b0;
    cmd.emit_op   = OP_REMOVE;
    cmd.emit_one  = 1'b0;
    cmd.emit_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = DP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat.cmd_ins) begin
          state_next = ST_INS_CHECK;
        end else if (stat.cmd_rem) begin
          if (stat.cnt_zero) begin
            cmd.emit     = 1'b1;
            cmd.emit_op  = OP_INSERT;
            cmd.emit_one = 1'b1;
            state_next   = ST_REM_EMIT;
          end else begin
            state_next = ST_POP_START;
          end
        end else begin
          state_next = ST_GET_RD;
        end
      end
      ST_INS_CHECK: begin
        cmd.op     = DP_SET_ERR;
        state_next = ST_INS_EMIT;
      end
      ST_INS_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_op   = OP_INSERT;
        cmd.emit_last = stat.cmd_ins;
        priority if (!stat.cnt_full) begin
          state_next = ST_PUSH_START;
        end else if (stat.cmd_ins) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_GET_EMIT;
        end
      end
      ST_PUSH_START: begin
        cmd.op     = DP_PUSH_START;
        state_next = ST_PUSH_RD;
      end
      ST_PUSH_RD: begin
        if (stat.idx_zero) begin
          state_next = ST_PUSH_END;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        if (stat.rd_lt_val || stat.rd_eq_val) begin
          state_next = ST_PUSH_END;
        end else begin
          cmd.op     = DP_PUSH_MOVE;
          state_next = ST_PUSH_RD;
        end
      end
      ST_PUSH_END: begin
        cmd.op     = DP_PUSH_END;
        state_next = stat.cmd_ins ? ST_IDLE : ST_GET_EMIT;
      end
      ST_POP_START: begin
        cmd.op     = DP_POP_START;
        cmd.rd_sel = RD_LAST;
        state_next = ST_POP_LAST;
      end
      ST_POP_LAST: begin
        cmd.op     = DP_POP_LAST;
        state_next = ST_POP_RL;
      end
      ST_POP_RL: begin
        if (stat.l_in) begin
          cmd.rd_sel = RD_LEFT;
          state_next = ST_POP_RR;
        end else begin
          state_next = ST_POP_END;
        end
      end
      ST_POP_RR: begin
        priority if (stat.r_in) begin
          cmd.op     = DP_LOAD_LVAL;
          cmd.rd_sel = RD_RIGHT;
          state_next = ST_POP_CMP;
        end else if (stat.rd_lt_mov) begin
          cmd.op     = DP_SINK_RD_L;
          state_next = ST_POP_RL;
        end else begin
          state_next = ST_POP_END;
        end
      end
      ST_POP_CMP: begin
        priority if (pick_right) begin
          cmd.op     = DP_SINK_RD_R;
          state_next = ST_POP_RL;
        end else if (stat.lval_lt_mov) begin
          cmd.op     = DP_SINK_LV_L;
          state_next = ST_POP_RL;
        end else begin
          state_next = ST_POP_END;
        end
      end
      ST_POP_END: begin
        cmd.op     = DP_POP_END;
        state_next = stat.cmd_rem ? ST_REM_EMIT : ST_GET_RD;
      end
      ST_GET_RD: begin
        if (stat.cnt_zero) begin
          state_next = ST_INS_CHECK;
        end else begin
          state_next = ST_GET_CMP;
        end
      end
      ST_GET_CMP: begin
        priority if (stat.rd_lt_val) begin
          cmd.emit   = 1'b1;
          state_next = ST_POP_START;
        end else if (stat.rd_eq_val) begin
          cmd.emit      = 1'b1;
          cmd.emit_op   = OP_GET;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_INS_CHECK;
        end
      end
      ST_GET_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_op   = OP_GET;
        cmd.emit_last = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_REM_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/min_heap_log_repair.sv */
// ----------------------------------------------------------------------------
// min_heap_log_repair
// Repairs a stream of min-heap operations against a bounded min-heap and
// emits the corrected operation sequence for each item.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  input    | start, busy              | command, value
//  result   | valid (one-cycle strobe) | op, op_value, last, full_error
//
//  The time an item takes depends on its data: each level of sift-up and
//  sift-down is paced by the single read port of the heap store. A getMin
//  repeats the pop for every smaller element. Reset clears the controller
//  state, the element count, the error flag and the valid strobe; the store
//  needs no clearing. Results cannot be stalled.
// ----------------------------------------------------------------------------
module min_heap_log_repair #(
  parameter int CAPACITY = mhlr_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [mhlr_pkg::OP_W-1:0]          command,
  input  logic signed [mhlr_pkg::VAL_W-1:0]  value,
  output logic                               valid,
  output logic [mhlr_pkg::OP_W-1:0]          op,
  output logic signed [mhlr_pkg::VAL_W-1:0]  op_value,
  output logic                               last,
  output logic                               full_error
);
  import mhlr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mhlr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  mhlr_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .command   (command),
    .value     (value),
    .valid     (valid),
    .op        (op),
    .op_value  (op_value),
    .last      (last),
    .full_error(full_error)
  );

endmodule

/* tb/sv/min_heap_log_repair_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_log_repair_check
// Watches the command and result channels of the heap log repair block. It
// keeps its own bounded min-heap and works out the repaired operation
// sequence for every accepted item. Each result strobe is then compared field
// by field with the oldest outstanding operation.
// ----------------------------------------------------------------------------
module min_heap_log_repair_check #(
  parameter int CAPACITY = mhlr_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [mhlr_pkg::OP_W-1:0]          command,
  input  logic signed [mhlr_pkg::VAL_W-1:0]  value,
  input  logic                               valid,
  input  logic [mhlr_pkg::OP_W-1:0]          op,
  input  logic signed [mhlr_pkg::VAL_W-1:0]  op_value,
  input  logic                               last,
  input  logic                               full_error,
  output int                                 mismatch_count,
  output int                                 ops_waiting
);
  import mhlr_pkg::*;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] val;
    logic                    last;
    logic                    dropped;
  } repaired_op_t;

  logic signed [VAL_W-1:0] heap_mem [CAPACITY];
  int                      heap_size = 0;
  repaired_op_t            repaired_ops[$];
  int                      errs = 0;

  function automatic void log_op(input op_t o, input logic signed [VAL_W-1:0] v);
    repaired_op_t e;
    e.op      = o;
    e.val     = v;
    e.last    = 1'b0;
    e.dropped = 1'b0;
    repaired_ops.insert(repaired_ops.size(), e);
  endfunction

  function automatic bit heap_insert(input logic signed [VAL_W-1:0] v);
    int                      i;
    int                      p;
    logic signed [VAL_W-1:0] t;
    if (heap_size >= CAPACITY) return 1'b0;
    i = heap_size;
    heap_mem[i] = v;
    heap_size++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_mem[p] <= heap_mem[i]) break;
      t           = heap_mem[p];
      heap_mem[p] = heap_mem[i];
      heap_mem[i] = t;
      i           = p;
    end
    return 1'b1;
  endfunction

  function automatic void heap_remove_min();
    int                      i;
    int                      l;
    int                      r;
    int                      m;
    logic signed [VAL_W-1:0] t;
    if (heap_size == 0) return;
    heap_size--;
    heap_mem[0] = heap_mem[heap_size];
    i = 0;
    while (1) begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_size && heap_mem[l] < heap_mem[m]) m = l;
      if (r < heap_size && heap_mem[r] < heap_mem[m]) m = r;
      if (m == i) break;
      t           = heap_mem[m];
      heap_mem[m] = heap_mem[i];
      heap_mem[i] = t;
      i           = m;
    end
  endfunction

  function automatic void repair_item(input logic [OP_W-1:0] cmd,
                                      input logic signed [VAL_W-1:0] v);
    int   first;
    logic dropped;
    first   = repaired_ops.size();
    dropped = 1'b0;
    case (cmd)
      OP_INSERT: begin
        if (!heap_insert(v)) dropped = 1'b1;
        log_op(OP_INSERT, v);
      end
      OP_REMOVE: begin
        if (heap_size == 0)
          log_op(OP_INSERT, 1);
        else
          heap_remove_min();
        log_op(OP_REMOVE, 0);
      end
      default: begin
        while (heap_size > 0 && heap_mem[0] < v) begin
          heap_remove_min();
          log_op(OP_REMOVE, 0);
        end
        if (heap_size == 0 || heap_mem[0] != v) begin
          if (!heap_insert(v)) dropped = 1'b1;
          log_op(OP_INSERT, v);
        end
        log_op(OP_GET, v);
      end
    endcase
    for (int k = first; k < repaired_ops.size(); k++)
      repaired_ops[k].dropped = dropped;
    repaired_ops[repaired_ops.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    repaired_op_t want;
    if (rst) begin
      heap_size = 0;
      repaired_ops.delete();
    end else begin
      if (start && !busy) repair_item(command, value);
      if (valid) begin
        if (repaired_ops.size() == 0) begin
          $error("unexpected result: op %0d op_value %0d", op, op_value);
          errs++;
        end else begin
          want = repaired_ops.pop_front();
          if (op !== want.op) begin
            $error("op: expected %0d, got %0d", want.op, op);
            errs++;
          end
          if (op_value !== want.val) begin
            $error("op_value: expected %0d, got %0d", want.val, op_value);
            errs++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errs++;
          end
          if (full_error !== want.dropped) begin
            $error("full_error: expected %0b, got %0b", want.dropped, full_error);
            errs++;
          end
        end
      end
    end
    mismatch_count <= errs;
    ops_waiting    <= repaired_ops.size();
  end

endmodule

/* tb/sv/min_heap_log_repair_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_log_repair_test
// Drives operation items into the heap log repair block: a directed set of
// corner cases, then fill bursts and weighted random mixes under three
// sender idling profiles. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module min_heap_log_repair_test;
  import mhlr_pkg::*;

  localparam logic [OP_W-1:0]  CMD_GET_ALIAS = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  logic                     clk;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic [OP_W-1:0]          command  = OP_INSERT;
  logic signed [VAL_W-1:0]  value    = '0;
  logic                     busy;
  logic                     valid;
  logic [OP_W-1:0]          op;
  logic signed [VAL_W-1:0]  op_value;
  logic                     last;
  logic                     full_error;
  int                       mismatch_count;
  int                       ops_waiting;
  int                       send_idle = 0;

  min_heap_log_repair uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .value      (value),
    .valid      (valid),
    .op         (op),
    .op_value   (op_value),
    .last       (last),
    .full_error (full_error)
  );

  min_heap_log_repair_check repair_chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .value          (value),
    .valid          (valid),
    .op             (op),
    .op_value       (op_value),
    .last           (last),
    .full_error     (full_error),
    .mismatch_count (mismatch_count),
    .ops_waiting    (ops_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic [OP_W-1:0] cmd, input logic signed [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    value   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int s;
    s = $urandom_range(0, 9);
    if (s < 4) begin
      s = $urandom_range(0, 16);
      return s - 8;
    end
    if (s < 6) begin
      case ($urandom_range(0, 5))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_MIN + 1;
        3:       return VAL_MAX - 1;
        4:       return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_command(input mix_t mix);
    int r;
    int w_ins;
    int w_rem;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        w_ins = 75;
        w_rem = 85;
      end
      MIX_BALANCED: begin
        w_ins = 40;
        w_rem = 65;
      end
      default: begin
        w_ins = 15;
        w_rem = 55;
      end
    endcase
    if (r < w_ins) return OP_INSERT;
    if (r < w_rem) return OP_REMOVE;
    if (r < 94)    return OP_GET;
    return CMD_GET_ALIAS;
  endfunction

  task automatic run_phase();
    mix_t mix;
    // empty all but the largest values, then fill past capacity
    send_item(OP_GET, VAL_MAX);
    for (int i = 0; i < CAPACITY_DEF + 2; i++)
      send_item(OP_INSERT, $urandom_range(0, 1000));
    send_item(OP_GET, VAL_MIN);
    send_item(OP_GET, VAL_MAX);
    mix = MIX_BALANCED;
    for (int i = 0; i < 36; i++) begin
      if (i % 12 == 0) mix = mix_t'($urandom_range(0, 2));
      send_item(pick_command(mix), pick_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_REMOVE, $urandom);
    send_item(CMD_GET_ALIAS, 5);
    send_item(OP_GET, 5);
    send_item(OP_INSERT, VAL_MIN);
    send_item(OP_INSERT, VAL_MAX);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, -1);
    send_item(OP_GET, VAL_MIN);
    send_item(OP_REMOVE, 32'h5555_5555);
    send_item(OP_GET, 3);
    send_item(OP_GET, VAL_MAX);
    send_item(OP_REMOVE, 32'haaaa_aaaa);
    send_item(OP_REMOVE, 0);
    send_item(OP_GET, -7);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_INSERT, 32'haaaa_aaaa);
    send_item(CMD_GET_ALIAS, VAL_MAX);
    send_item(OP_REMOVE, -1);

    send_idle = 37;
    run_phase();
    send_idle = 48;
    run_phase();
    send_idle = 0;
    run_phase();

    start <= 1'b0;
    @(posedge clk);
    while (ops_waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && ops_waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mhlr_pkg.sv
src/mhlr_ram.sv
src/mhlr_dp.sv
src/mhlr_ctrl.sv
src/min_heap_log_repair.sv
tb/sv/min_heap_log_repair_check.sv
tb/sv/min_heap_log_repair_test.sv
